[rtl/lwff_pkg.sv]
`timescale 1ns / 1ps
// Package for the low-rate WPAN receive frame filter.
// Holds the shared constants, verdict codes, queue record type and CRC step.
package lwff_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 256;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW = $clog2(Q_DEPTH);

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [8:0] COUNT_MAX = 9'd511;
  localparam logic [9:0] LEN_MIN = 10'd11;
  localparam logic [9:0] LEN_ACK = 10'd6;
  localparam logic [9:0] LEN_MAX = 10'(MAX_FRAME_BYTES);
  localparam logic [15:0] TOTAL_MAX = 16'hffff;

  localparam logic [7:0] FC_ACK = 8'h40;
  localparam logic [7:0] ACK_FC_HIGH = 8'h00;
  localparam logic [7:0] ACK_TRAILER = 8'h7f;
  localparam logic [7:0] ADDR_BROADCAST = 8'hff;

  localparam logic [7:0] REG_OWN_ADDR_FIRST = 8'd0;
  localparam logic [7:0] REG_OWN_ADDR_SECOND = 8'd1;
  localparam logic [7:0] OWN_ADDR_FIRST_RESET = 8'h42;
  localparam logic [7:0] OWN_ADDR_SECOND_RESET = 8'he8;

  typedef enum logic [2:0] {
    VERDICT_LENGTH    = 3'd0,
    VERDICT_CRC_ERROR = 3'd1,
    VERDICT_ACK_RX    = 3'd2,
    VERDICT_DATA_ME   = 3'd3,
    VERDICT_DROP_ADDR = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    STEP_VERDICT  = 3'd0,
    STEP_ACK_FC   = 3'd1,
    STEP_ACK_FCH  = 3'd2,
    STEP_ACK_SEQ  = 3'd3,
    STEP_ACK_CRCL = 3'd4,
    STEP_ACK_CRCH = 3'd5,
    STEP_ACK_END  = 3'd6
  } step_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  seq;
    logic [15:0] error_total;
    logic [15:0] received_total;
    logic        send_ack;
  } job_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = b[k] ^ r[0];
      r = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

[rtl/lwff_intf.sv]
`timescale 1ns / 1ps
// Channel interfaces of the frame filter: received bytes, results, register writes.
// Each carries valid, ready and its payload; no dependencies.
interface lwff_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface lwff_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  verdict;
  logic [7:0]  seq_number;
  logic [7:0]  ack_byte;
  logic [15:0] error_total;
  logic [15:0] received_total;
  logic        last;
  modport source (output valid, output kind, output verdict, output seq_number,
                  output ack_byte, output error_total, output received_total,
                  output last, input ready);
  modport sink (input valid, input kind, input verdict, input seq_number,
                input ack_byte, input error_total, input received_total,
                input last, output ready);
endinterface

interface lwff_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/lowrate_wpan_rx_frame_filter.sv]
`timescale 1ns / 1ps
// Top level of the low-rate WPAN receive frame filter.
// Depends on lwff_pkg, the channel interfaces, lwff_front, lwff_queue and lwff_back.
//
// Received bytes are taken at one per cycle. Ordinary bytes produce nothing; the trailer
// byte of each frame produces a verdict record that the front part places in a four-entry
// queue, and the back part emits it as one result, followed by six ACK bytes for unicast
// data addressed to this node, one result per cycle while the result channel is ready. The
// input stalls only while the queue is full, which happens when frames end faster than the
// output drains them (a frame with an ACK occupies the output for seven results). Address
// registers are written through the configuration channel, which is always ready.
module lowrate_wpan_rx_frame_filter
  import lwff_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lwff_rx_if.sink     rx,
  lwff_cfg_if.sink    cfg,
  lwff_res_if.source  res
);

  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_avail;
  job_t q_pop_job;

  lwff_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_push_job)
  );

  lwff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_job  (q_pop_job)
  );

  lwff_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_job   (q_pop_job),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

[rtl/lwff_front.sv]
`timescale 1ns / 1ps
// Front part: takes frame bytes, runs the CRC, keeps header bytes and issues a verdict record.
// Depends on lwff_pkg and the channel interfaces.
module lwff_front
  import lwff_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lwff_rx_if.sink     rx,
  lwff_cfg_if.sink    cfg,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [15:0] crc_reg;
  logic [8:0]  byte_count;
  logic [7:0]  frame_control_low;
  logic [7:0]  seq_store;
  logic [7:0]  addr_bytes [4];
  logic [15:0] error_counter;
  logic [15:0] received_counter;
  logic [7:0]  own_addr_first;
  logic [7:0]  own_addr_second;

  logic        rx_xfer;
  logic [9:0]  frame_len;
  verdict_t    verdict;
  logic        send_ack;
  logic [15:0] error_counter_next;
  logic [15:0] received_counter_next;

  assign rx.ready = !q_full;
  assign cfg.ready = 1'b1;
  assign rx_xfer = rx.valid && rx.ready;
  assign q_push = rx_xfer && rx.frame_end;
  assign frame_len = {1'b0, byte_count} + 10'd1;

  always_comb begin
    verdict = VERDICT_DROP_ADDR;
    send_ack = 1'b0;
    error_counter_next = error_counter;
    received_counter_next = received_counter;
    if ((frame_len < LEN_MIN && frame_len != LEN_ACK) || frame_len > LEN_MAX) begin
      verdict = VERDICT_LENGTH;
    end else if (crc_reg != 16'd0) begin
      verdict = VERDICT_CRC_ERROR;
      if (error_counter != TOTAL_MAX) begin
        error_counter_next = error_counter + 16'd1;
      end
    end else if (frame_control_low == FC_ACK) begin
      verdict = VERDICT_ACK_RX;
    end else if (frame_len == LEN_ACK) begin
      verdict = VERDICT_DROP_ADDR;
    end else if ((own_addr_first != addr_bytes[2] || own_addr_second != addr_bytes[3])
                 && own_addr_first == addr_bytes[0] && own_addr_second == addr_bytes[1]) begin
      verdict = VERDICT_DATA_ME;
      if (received_counter != TOTAL_MAX) begin
        received_counter_next = received_counter + 16'd1;
      end
      send_ack = addr_bytes[0] != ADDR_BROADCAST || addr_bytes[1] != ADDR_BROADCAST;
    end
  end

  always_comb begin
    q_job.verdict = verdict;
    q_job.seq = seq_store;
    q_job.error_total = error_counter_next;
    q_job.received_total = received_counter_next;
    q_job.send_ack = send_ack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= '0;
      byte_count <= '0;
      frame_control_low <= '0;
      seq_store <= '0;
      for (int i = 0; i < 4; i++) begin
        addr_bytes[i] <= '0;
      end
      error_counter <= '0;
      received_counter <= '0;
      own_addr_first <= OWN_ADDR_FIRST_RESET;
      own_addr_second <= OWN_ADDR_SECOND_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_OWN_ADDR_FIRST) begin
          own_addr_first <= cfg.data;
        end else if (cfg.index == REG_OWN_ADDR_SECOND) begin
          own_addr_second <= cfg.data;
        end
      end
      if (rx_xfer) begin
        if (!rx.frame_end) begin
          crc_reg <= crc16_byte(crc_reg, rx.rx_byte);
          if (byte_count == 9'd0) begin
            frame_control_low <= rx.rx_byte;
          end
          if (byte_count == 9'd2) begin
            seq_store <= rx.rx_byte;
          end
          for (int i = 0; i < 4; i++) begin
            if (byte_count == 9'(i + 5)) begin
              addr_bytes[i] <= rx.rx_byte;
            end
          end
          if (byte_count != COUNT_MAX) begin
            byte_count <= byte_count + 9'd1;
          end
        end else begin
          crc_reg <= '0;
          byte_count <= '0;
          frame_control_low <= '0;
          seq_store <= '0;
          for (int i = 0; i < 4; i++) begin
            addr_bytes[i] <= '0;
          end
          error_counter <= error_counter_next;
          received_counter <= received_counter_next;
        end
      end
    end
  end

endmodule

[rtl/lwff_queue.sv]
`timescale 1ns / 1ps
// Short register queue of verdict records between the front and back parts.
// Depends on lwff_pkg.
module lwff_queue
  import lwff_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t pop_job
);

  job_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full = count == (Q_AW+1)'(Q_DEPTH);
  assign avail = count != '0;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/lwff_back.sv]
`timescale 1ns / 1ps
// Back part: turns a verdict record into the verdict result and, when due, six ACK bytes.
// Depends on lwff_pkg and the result interface.
module lwff_back
  import lwff_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  job_t       q_job,
  output logic       q_pop,
  lwff_res_if.source res
);

  job_t        cur;
  logic        cur_valid;
  step_t       step;
  logic        out_load;
  logic        cur_last;
  logic [15:0] ack_crc;

  logic        kind_next;
  logic [7:0]  ack_byte_next;

  assign out_load = cur_valid && (!res.valid || res.ready);
  assign cur_last = (step == STEP_VERDICT && !cur.send_ack) || step == STEP_ACK_END;
  assign q_pop = q_avail && (!cur_valid || (out_load && cur_last));
  assign ack_crc = crc16_byte(crc16_byte(crc16_byte(16'd0, FC_ACK), ACK_FC_HIGH), cur.seq);

  always_comb begin
    kind_next = 1'b1;
    ack_byte_next = 8'd0;
    unique case (step)
      STEP_VERDICT: kind_next = 1'b0;
      STEP_ACK_FC: ack_byte_next = FC_ACK;
      STEP_ACK_FCH: ack_byte_next = ACK_FC_HIGH;
      STEP_ACK_SEQ: ack_byte_next = cur.seq;
      STEP_ACK_CRCL: ack_byte_next = ack_crc[7:0];
      STEP_ACK_CRCH: ack_byte_next = ack_crc[15:8];
      STEP_ACK_END: ack_byte_next = ACK_TRAILER;
      default: kind_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.kind <= kind_next;
      res.verdict <= kind_next ? VERDICT_DATA_ME : cur.verdict;
      res.seq_number <= cur.seq;
      res.ack_byte <= ack_byte_next;
      res.error_total <= cur.error_total;
      res.received_total <= cur.received_total;
      res.last <= cur_last;
    end
    if (q_pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      cur_valid <= 1'b0;
      step <= STEP_VERDICT;
    end else begin
      if (out_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        step <= STEP_VERDICT;
      end else if (out_load) begin
        if (cur_last) begin
          cur_valid <= 1'b0;
          step <= STEP_VERDICT;
        end else begin
          step <= step_t'(step + 3'd1);
        end
      end
    end
  end

endmodule
